// ===== rtl/core/bole_pkg.sv =====
// Shared widths, command and status codes, and control/status bundles for the list engine.
package bole_pkg;

   localparam int BOLE_CAPACITY = 32;

   localparam int CMD_W  = 4;
   localparam int DATA_W = 32;
   localparam int POS_W  = 7;
   localparam int STAT_W = 3;

   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INS_BACK  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INS_AT    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 4'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_DEL_AT    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd6;
   localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd7;
   localparam logic [CMD_W-1:0] CMD_READ_ALL  = 4'd8;

   localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
   localparam logic [STAT_W-1:0] ST_MISS   = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic load_req;   // capture the request beat
      logic exec_emit;  // single-beat commands: apply and emit
      logic match;      // register the search match vector
      logic find_emit;  // emit the search result
      logic dump_emit;  // emit head element and rotate the list
   } bole_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             list_empty;
      logic             dump_last;
      logic             out_free;
   } bole_sts_type;

endpackage

// ===== rtl/core/bole_if.sv =====
// Request and response channel interfaces for the list engine.
interface bole_req_if;
   import bole_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [DATA_W-1:0] item_value;
   logic [POS_W-1:0]         position;

   modport source (output valid, output command, output item_value, output position,
                   input ready);
   modport sink (input valid, input command, input item_value, input position,
                 output ready);
endinterface

interface bole_rsp_if;
   import bole_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] value_out;
   logic [POS_W-1:0]         index_out;
   logic                     last;

   modport source (output valid, output status, output value_out, output index_out,
                   output last, input ready);
   modport sink (input valid, input status, input value_out, input index_out,
                 input last, output ready);
endinterface

// ===== rtl/core/bole_ctrl.sv =====
// Command sequencer for the list engine.
module bole_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bole_pkg::bole_sts_type sts,
   output bole_pkg::bole_ctl_type ctl
);
   import bole_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_FIND = 2'd2;
   localparam logic [1:0] S_DUMP = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      ctl       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.out_free) begin
               priority if (sts.command == CMD_SEARCH && !sts.list_empty) begin
                  ctl.match = 1'b1;
                  state_in  = S_FIND;
               end else if (sts.command == CMD_READ_ALL && !sts.list_empty) begin
                  state_in = S_DUMP;
               end else begin
                  ctl.exec_emit = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         S_FIND: begin
            if (sts.out_free) begin
               ctl.find_emit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DUMP: begin
            if (sts.out_free) begin
               ctl.dump_emit = 1'b1;
               if (sts.dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted beat did not move to execute");

   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> !sts.list_empty)
      else $error("read-out running on an empty list");
`endif

endmodule

// ===== rtl/core/bole_dp.sv =====
// List storage cells, count, search match vector and response register.
module bole_dp #(
   parameter int CAPACITY = bole_pkg::BOLE_CAPACITY
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [bole_pkg::CMD_W-1:0]             req_command,
   input  logic signed [bole_pkg::DATA_W-1:0]     req_item_value,
   input  logic [bole_pkg::POS_W-1:0]             req_position,
   input  bole_pkg::bole_ctl_type                 ctl,
   output bole_pkg::bole_sts_type                 sts,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [bole_pkg::STAT_W-1:0]            rsp_status,
   output logic signed [bole_pkg::DATA_W-1:0]     rsp_value_out,
   output logic [bole_pkg::POS_W-1:0]             rsp_index_out,
   output logic                                   rsp_last
);
   import bole_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // captured request
   logic [CMD_W-1:0]         cmd_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [POS_W-1:0]         pos_ff;

   logic signed [DATA_W-1:0] cell_ff [CAPACITY];
   logic signed [DATA_W-1:0] cell_in [CAPACITY];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         dump_idx_ff, dump_idx_in;
   logic [CAPACITY-1:0]      match_ff, match_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]         index_ff, index_in;
   logic                     last_ff, last_in;

   logic [POS_W-1:0]         cnt7;
   logic                     is_empty, is_full, is_ins, is_del;
   logic                     ins_bad, del_bad;
   logic [POS_W-1:0]         ins_at, del_at, rot_last;
   logic signed [DATA_W-1:0] removed;
   logic [STAT_W-1:0]        res_status;
   logic signed [DATA_W-1:0] res_value;
   logic [POS_W-1:0]         res_index;
   logic                     do_ins, do_del;
   logic [CAPACITY-1:0]      low_bit;
   logic [POS_W-1:0]         found_idx;
   logic                     found;
   logic [POS_W-1:0]         dump_next;
   logic                     dump_last;
   logic                     out_free;

   assign cnt7     = POS_W'(count_ff);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_ins   = (cmd_ff == CMD_INS_FRONT) || (cmd_ff == CMD_INS_BACK) ||
                     (cmd_ff == CMD_INS_AT);
   assign is_del   = (cmd_ff == CMD_DEL_FRONT) || (cmd_ff == CMD_DEL_BACK) ||
                     (cmd_ff == CMD_DEL_AT);
   assign ins_bad  = (cmd_ff == CMD_INS_AT) &&
                     ((pos_ff == '0) || (pos_ff > cnt7 + POS_W'(1)));
   assign del_bad  = (cmd_ff == CMD_DEL_AT) && ((pos_ff == '0) || (pos_ff > cnt7));
   assign rot_last = cnt7 - POS_W'(1);

   always_comb begin
      unique case (cmd_ff)
         CMD_INS_FRONT: ins_at = '0;
         CMD_INS_BACK:  ins_at = cnt7;
         default:       ins_at = pos_ff - POS_W'(1);
      endcase
      unique case (cmd_ff)
         CMD_DEL_FRONT: del_at = '0;
         CMD_DEL_BACK:  del_at = cnt7 - POS_W'(1);
         default:       del_at = pos_ff - POS_W'(1);
      endcase
   end

   // value leaving on a delete: AND-OR select across the cells
   always_comb begin
      removed = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (POS_W'(i) == del_at) begin
            removed = removed | cell_ff[i];
         end
      end
   end

   // single-beat result
   always_comb begin
      res_status = ST_OK;
      res_value  = '0;
      res_index  = cnt7;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      priority if (is_ins) begin
         priority if (ins_bad) begin
            res_status = ST_BADPOS;
         end else if (is_full) begin
            res_status = ST_FULL;
         end else begin
            do_ins    = 1'b1;
            res_index = cnt7 + POS_W'(1);
         end
      end else if (is_empty && (is_del || cmd_ff == CMD_SEARCH || cmd_ff == CMD_READ_ALL)) begin
         res_status = ST_EMPTY;
         res_index  = '0;
      end else if (is_del) begin
         if (del_bad) begin
            res_status = ST_BADPOS;
         end else begin
            do_del    = 1'b1;
            res_value = removed;
            res_index = cnt7 - POS_W'(1);
         end
      end else begin
         res_status = ST_OK;
      end
   end

   // cell moves: shift up on insert, down on delete, rotate by one on read-out
   always_comb begin
      cell_in = cell_ff;
      priority if (ctl.exec_emit && do_ins) begin
         if (ins_at == '0) begin
            cell_in[0] = val_ff;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (POS_W'(i) == ins_at) begin
               cell_in[i] = val_ff;
            end else if (POS_W'(i) > ins_at) begin
               cell_in[i] = cell_ff[i-1];
            end
         end
      end else if (ctl.exec_emit && do_del) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (POS_W'(i) >= del_at) begin
               cell_in[i] = cell_ff[i+1];
            end
         end
      end else if (ctl.dump_emit) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (POS_W'(i) == rot_last) begin
               cell_in[i] = cell_ff[0];
            end else if (POS_W'(i) < rot_last) begin
               cell_in[i] = cell_ff[i+1];
            end
         end
         if (POS_W'(CAPACITY - 1) == rot_last) begin
            cell_in[CAPACITY-1] = cell_ff[0];
         end
      end else begin
         cell_in = cell_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.exec_emit && do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.exec_emit && do_del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // search: parallel compare, then lowest set bit
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (cell_ff[i] == val_ff) && (POS_W'(i) < cnt7);
      end
   end

   assign low_bit = match_ff & (~match_ff + CAPACITY'(1));
   assign found   = |match_ff;

   always_comb begin
      found_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (low_bit[i]) begin
            found_idx = found_idx | POS_W'(i + 1);
         end
      end
   end

   // read-out position
   assign dump_next = POS_W'(dump_idx_ff) + POS_W'(1);
   assign dump_last = (dump_next == cnt7);

   always_comb begin
      dump_idx_in = dump_idx_ff;
      if (ctl.load_req) begin
         dump_idx_in = '0;
      end else if (ctl.dump_emit) begin
         dump_idx_in = dump_idx_ff + CNT_W'(1);
      end
   end

   // response register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      last_in      = last_ff;
      priority if (ctl.exec_emit) begin
         rsp_valid_in = 1'b1;
         status_in    = res_status;
         value_in     = res_value;
         index_in     = res_index;
         last_in      = 1'b1;
      end else if (ctl.find_emit) begin
         rsp_valid_in = 1'b1;
         status_in    = found ? ST_OK : ST_MISS;
         value_in     = '0;
         index_in     = found ? found_idx : cnt7;
         last_in      = 1'b1;
      end else if (ctl.dump_emit) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         value_in     = cell_ff[0];
         index_in     = dump_next;
         last_in      = dump_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff   <= cell_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      index_ff  <= index_in;
      last_ff   <= last_in;
      if (ctl.load_req) begin
         cmd_ff <= req_command;
         val_ff <= req_item_value;
         pos_ff <= req_position;
      end
      if (ctl.match) begin
         match_ff <= match_in;
      end
   end

   assign sts.command    = cmd_ff;
   assign sts.list_empty = is_empty;
   assign sts.dump_last  = dump_last;
   assign sts.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_value_out = value_ff;
   assign rsp_index_out = index_ff;
   assign rsp_last      = last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_dump_keeps_count: assert property (@(posedge clock) disable iff (reset)
      ctl.dump_emit |=> $stable(count_ff))
      else $error("read-out rotation changed the entry count");
`endif

endmodule

// ===== rtl/core/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: sequencer plus list datapath.
// Each command is captured, then executed; a search on a non-empty list adds a find step
//   (parallel compare is registered, then the first match is encoded), and read all
//   on a non-empty list goes on to a read-out step that emits the beats.
// Read all: one beat per cycle as the list rotates, while the receiver takes each beat.
// The sequencer takes no new request until the last result beat of a command is emitted.
// Reset (synchronous): clears entry count, sequencer and response valid; cells keep data.
module bounded_ordered_list_engine #(
   parameter int CAPACITY = bole_pkg::BOLE_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   bole_req_if.sink   req_bus,
   bole_rsp_if.source rsp_bus
);
   import bole_pkg::*;

   // command and status bundles between sequencer and datapath
   bole_ctl_type ctl;
   bole_sts_type sts;
   logic         req_ready;

   // The sequencer takes one request beat at a time: capture, execute,
   // then either one result beat (most commands), a search finish beat,
   // or a run of read-out beats. Every beat waits on the response register.
   bole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // The datapath holds the list as a row of shifting cells, packed from
   // the head. Insert shifts up, delete shifts down, read-out rotates the
   // live part by one per beat so the list is back in order at the end.
   bole_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_bus.command),
      .req_item_value (req_bus.item_value),
      .req_position   (req_bus.position),
      .ctl            (ctl),
      .sts            (sts),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_status     (rsp_bus.status),
      .rsp_value_out  (rsp_bus.value_out),
      .rsp_index_out  (rsp_bus.index_out),
      .rsp_last       (rsp_bus.last)
   );

   assign req_bus.ready = req_ready;

endmodule

// ===== tb/bounded_ordered_list_engine_test.sv =====
// Self-checking testbench for the bounded ordered list engine: directed table, then random traffic.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_test;
   import bole_pkg::*;

   // Command codes the block does not decode; they still answer with one beat.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

   localparam int OPENING_ROWS    = 25;
   localparam int RANDOM_COMMANDS = 210;
   localparam int STALL_LIMIT     = 3000;  // cycles with no beat on either side
   localparam int HOLD_CYCLES     = 400;   // one long receiver hold-off
   localparam int HOLD_AFTER      = 150;   // result beats seen before the hold
   localparam int DRAIN_TAIL      = 20;    // quiet cycles after the last result
   localparam int REPORT_MAX      = 10;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] item_value;
      logic [POS_W-1:0]         position;
   } cmd_beat_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] value_out;
      logic [POS_W-1:0]         index_out;
      logic                     last;
   } rsp_beat_type;

   // One row of the opening table. Where typed is set, the result beat is
   // written out by hand; otherwise the list model supplies it.
   typedef struct packed {
      cmd_beat_type beat;
      logic         typed;
      rsp_beat_type want;
   } opening_row_type;

   localparam rsp_beat_type NO_RSP = '{ST_OK, 32'sd0, 7'd0, 1'b0};

   logic clock;
   logic reset;

   bole_req_if req_bus ();
   bole_rsp_if rsp_bus ();

   bounded_ordered_list_engine i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // List model: contents in order, front at index 0, and the result beats
   // still owed by the block, oldest first.
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0] shadow_list [$];
   rsp_beat_type             owed_beats [$];

   int  commands_taken = 0;
   int  beats_checked  = 0;
   int  fault_count    = 0;
   int  depth_peak     = 0;
   int  status_tally [8];
   bit  calm           = 1'b0;  // no idling on either side while set

   function automatic void owe_beat(input logic [STAT_W-1:0] status,
                                    input logic signed [DATA_W-1:0] value, input int index,
                                    input logic last);
      rsp_beat_type beat;
      beat.status    = status;
      beat.value_out = value;
      beat.index_out = index[POS_W-1:0];
      beat.last      = last;
      owed_beats.push_back(beat);
      status_tally[status]++;
   endfunction

   // Apply one accepted command to the model and queue the beats it causes.
   function automatic void list_apply(input cmd_beat_type beat);
      int n;
      int pos;
      int at;
      int hit;
      logic signed [DATA_W-1:0] taken;
      n   = shadow_list.size();
      pos = int'(beat.position);
      case (beat.command)
         CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
            // a bad position wins over a full list
            if (beat.command == CMD_INS_AT && (pos < 1 || pos > n + 1)) begin
               owe_beat(ST_BADPOS, '0, n, 1'b1);
            end else if (n >= BOLE_CAPACITY) begin
               owe_beat(ST_FULL, '0, n, 1'b1);
            end else begin
               if (beat.command == CMD_INS_FRONT) at = 0;
               else if (beat.command == CMD_INS_BACK) at = n;
               else at = pos - 1;
               shadow_list.insert(at, beat.item_value);
               owe_beat(ST_OK, '0, n + 1, 1'b1);
            end
         end
         CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
            // empty wins over a bad position
            if (n == 0) begin
               owe_beat(ST_EMPTY, '0, 0, 1'b1);
            end else if (beat.command == CMD_DEL_AT && (pos < 1 || pos > n)) begin
               owe_beat(ST_BADPOS, '0, n, 1'b1);
            end else begin
               if (beat.command == CMD_DEL_FRONT) at = 0;
               else if (beat.command == CMD_DEL_BACK) at = n - 1;
               else at = pos - 1;
               taken = shadow_list[at];
               shadow_list.delete(at);
               owe_beat(ST_OK, taken, n - 1, 1'b1);
            end
         end
         CMD_SEARCH: begin
            if (n == 0) begin
               owe_beat(ST_EMPTY, '0, 0, 1'b1);
            end else begin
               hit = 0;
               for (int i = 0; i < n && hit == 0; i++) begin
                  if (shadow_list[i] == beat.item_value) hit = i + 1;
               end
               if (hit != 0) owe_beat(ST_OK, '0, hit, 1'b1);
               else owe_beat(ST_MISS, '0, n, 1'b1);
            end
         end
         CMD_READ_ALL: begin
            if (n == 0) begin
               owe_beat(ST_EMPTY, '0, 0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  owe_beat(ST_OK, shadow_list[i], i + 1, (i == n - 1));
               end
            end
         end
         default: begin
            // count and the spare codes: count only, list untouched
            owe_beat(ST_OK, '0, n, 1'b1);
         end
      endcase
      if (shadow_list.size() > depth_peak) depth_peak = shadow_list.size();
   endfunction

   // ---------------------------------------------------------------------
   // Random command source. Growing phases lean on inserts, shrinking ones
   // on deletes, so the list sweeps between empty and full.
   // ---------------------------------------------------------------------
   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(9))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_beat_type random_command(input bit growing);
      cmd_beat_type beat;
      int n;
      int roll;
      int ins_share;
      int del_share;
      n         = shadow_list.size();
      roll      = $urandom_range(99);
      ins_share = growing ? 55 : 20;
      del_share = 75 - ins_share;
      beat.item_value = random_value();
      beat.position   = POS_W'($urandom_range(127));
      if (roll < ins_share) begin
         case ($urandom_range(2))
            0: beat.command = CMD_INS_FRONT;
            1: beat.command = CMD_INS_BACK;
            default: begin
               beat.command = CMD_INS_AT;
               if ($urandom_range(99) < 85) beat.position = POS_W'($urandom_range(n + 1, 1));
            end
         endcase
      end else if (roll < ins_share + del_share) begin
         case ($urandom_range(2))
            0: beat.command = CMD_DEL_FRONT;
            1: beat.command = CMD_DEL_BACK;
            default: begin
               beat.command = CMD_DEL_AT;
               if (n > 0 && $urandom_range(99) < 85)
                  beat.position = POS_W'($urandom_range(n, 1));
            end
         endcase
      end else if (roll < 88) begin
         beat.command = CMD_SEARCH;
         // half the searches look for something that is there
         if (n > 0 && $urandom_range(1) == 1) beat.item_value = shadow_list[$urandom_range(n - 1)];
      end else if (roll < 94) begin
         beat.command = CMD_READ_ALL;
      end else if (roll < 97) begin
         beat.command = CMD_COUNT;
      end else begin
         beat.command = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      end
      return beat;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Entered and left at a falling edge; valid stays up
   // across back-to-back beats.
   // ---------------------------------------------------------------------
   task automatic offer_command(input cmd_beat_type beat, input logic typed,
                                input rsp_beat_type want);
      while (!calm && $urandom_range(99) < 31) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= beat.command;
      req_bus.item_value <= beat.item_value;
      req_bus.position   <= beat.position;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      commands_taken++;
      list_apply(beat);
      // hand-written rows replace the model's single beat
      if (typed) owed_beats[owed_beats.size() - 1] = want;
      @(negedge clock);
   endtask

   // Opening table: empty-list corners, position bounds, extreme values,
   // first-match search with a duplicate, and a spare command code.
   opening_row_type opening_rows [OPENING_ROWS] = '{
      '{'{CMD_DEL_FRONT, 32'sd0, 7'd0},             1'b1, '{ST_EMPTY, 32'sd0, 7'd0, 1'b1}},
      '{'{CMD_DEL_BACK, 32'sd0, 7'd0},              1'b1, '{ST_EMPTY, 32'sd0, 7'd0, 1'b1}},
      '{'{CMD_DEL_AT, 32'sd0, 7'd1},                1'b1, '{ST_EMPTY, 32'sd0, 7'd0, 1'b1}},
      '{'{CMD_DEL_AT, 32'sd0, 7'd0},                1'b1, '{ST_EMPTY, 32'sd0, 7'd0, 1'b1}},
      '{'{CMD_SEARCH, 32'sd0, 7'd0},                1'b1, '{ST_EMPTY, 32'sd0, 7'd0, 1'b1}},
      '{'{CMD_READ_ALL, 32'sd0, 7'd0},              1'b1, '{ST_EMPTY, 32'sd0, 7'd0, 1'b1}},
      '{'{CMD_COUNT, 32'sd0, 7'd0},                 1'b1, '{ST_OK, 32'sd0, 7'd0, 1'b1}},
      '{'{CMD_INS_AT, 32'sd5, 7'd0},                1'b1, '{ST_BADPOS, 32'sd0, 7'd0, 1'b1}},
      '{'{CMD_INS_AT, 32'sd5, 7'd2},                1'b1, '{ST_BADPOS, 32'sd0, 7'd0, 1'b1}},
      '{'{CMD_INS_FRONT, 32'sh7fff_ffff, 7'd0},     1'b1, '{ST_OK, 32'sd0, 7'd1, 1'b1}},
      '{'{CMD_INS_BACK, 32'sh8000_0000, 7'd0},      1'b1, '{ST_OK, 32'sd0, 7'd2, 1'b1}},
      '{'{CMD_INS_AT, 32'sd0, 7'd2},                1'b1, '{ST_OK, 32'sd0, 7'd3, 1'b1}},
      '{'{CMD_INS_AT, -32'sd1, 7'd4},               1'b1, '{ST_OK, 32'sd0, 7'd4, 1'b1}},
      '{'{CMD_INS_AT, -32'sd1, 7'd1},               1'b1, '{ST_OK, 32'sd0, 7'd5, 1'b1}},
      '{'{CMD_INS_AT, 32'sd9, 7'd127},              1'b1, '{ST_BADPOS, 32'sd0, 7'd5, 1'b1}},
      '{'{CMD_SEARCH, -32'sd1, 7'd0},               1'b1, '{ST_OK, 32'sd0, 7'd1, 1'b1}},
      '{'{CMD_SEARCH, 32'sh8000_0000, 7'd0},        1'b1, '{ST_OK, 32'sd0, 7'd4, 1'b1}},
      '{'{CMD_SEARCH, 32'sd5, 7'd0},                1'b1, '{ST_MISS, 32'sd0, 7'd5, 1'b1}},
      '{'{CMD_READ_ALL, 32'sd0, 7'd0},              1'b0, NO_RSP},
      '{'{CMD_DEL_AT, 32'sd0, 7'd6},                1'b1, '{ST_BADPOS, 32'sd0, 7'd5, 1'b1}},
      '{'{CMD_DEL_AT, 32'sd0, 7'd0},                1'b1, '{ST_BADPOS, 32'sd0, 7'd5, 1'b1}},
      '{'{CMD_DEL_AT, 32'sd0, 7'd3},                1'b1, '{ST_OK, 32'sd0, 7'd4, 1'b1}},
      '{'{CMD_DEL_FRONT, 32'sd0, 7'd0},             1'b1, '{ST_OK, -32'sd1, 7'd3, 1'b1}},
      '{'{CMD_DEL_BACK, 32'sd0, 7'd0},              1'b1, '{ST_OK, -32'sd1, 7'd2, 1'b1}},
      '{'{CMD_SPARE_HI, 32'sd0, 7'd0},              1'b1, '{ST_OK, 32'sd0, 7'd2, 1'b1}}
   };

   initial begin
      cmd_beat_type beat;
      bit           growing;
      int           n;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_COUNT;
      req_bus.item_value = '0;
      req_bus.position   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_rows[r]) begin
         offer_command(opening_rows[r].beat, opening_rows[r].typed, opening_rows[r].want);
      end

      // Fill to capacity with random values, then hit the full-list cases:
      // insert at count+1 is full, count+2 is a bad position first.
      while (shadow_list.size() < BOLE_CAPACITY) begin
         beat = '{CMD_INS_BACK, random_value(), 7'd0};
         offer_command(beat, 1'b0, NO_RSP);
      end
      n = BOLE_CAPACITY;
      offer_command(cmd_beat_type'{CMD_INS_FRONT, 32'sd1, 7'd0}, 1'b0, NO_RSP);
      offer_command(cmd_beat_type'{CMD_INS_AT, 32'sd1, 7'(n + 1)}, 1'b0, NO_RSP);
      offer_command(cmd_beat_type'{CMD_INS_AT, 32'sd1, 7'(n + 2)}, 1'b0, NO_RSP);
      offer_command(cmd_beat_type'{CMD_INS_BACK, 32'sd1, 7'd0}, 1'b0, NO_RSP);
      offer_command(cmd_beat_type'{CMD_SEARCH, shadow_list[n - 1], 7'd0}, 1'b0, NO_RSP);
      offer_command(cmd_beat_type'{CMD_READ_ALL, 32'sd0, 7'd0}, 1'b0, NO_RSP);

      // Random traffic; shrink first since the list is full here.
      growing = 1'b0;
      for (int k = 0; k < RANDOM_COMMANDS; k++) begin
         calm = (k >= 110 && k < 170);
         if (growing && shadow_list.size() >= BOLE_CAPACITY && $urandom_range(3) == 0)
            growing = 1'b0;
         else if (!growing && shadow_list.size() == 0 && $urandom_range(3) == 0)
            growing = 1'b1;
         beat = random_command(growing);
         offer_command(beat, 1'b0, NO_RSP);
      end
      req_bus.valid <= 1'b0;

      while (owed_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (owed_beats.size() != 0) begin
         $display("%0d result beats never arrived", owed_beats.size());
         fault_count += owed_beats.size();
      end

      $display("%0d commands, %0d result beats checked; list depth reached %0d of %0d",
               commands_taken, beats_checked, depth_peak, BOLE_CAPACITY);
      $display("rejections: %0d full, %0d bad position, %0d empty, %0d search misses",
               status_tally[ST_FULL], status_tally[ST_BADPOS], status_tally[ST_EMPTY],
               status_tally[ST_MISS]);
      if (fault_count == 0) begin
         $display("bounded_ordered_list_engine test passed");
      end else begin
         $display("bounded_ordered_list_engine test failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, plus one long hold-off so the
   // block backs up and stalls the request channel.
   // ---------------------------------------------------------------------
   initial begin
      bit held;
      held          = 1'b0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!held && beats_checked >= HOLD_AFTER) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_bus.ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= 31);
         @(negedge clock);
      end
   end

   // Result checker: every beat against the oldest owed beat.
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.status, rsp_bus.value_out, rsp_bus.index_out, rsp_bus.last};
         beats_checked++;
         if (owed_beats.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("unexpected result beat: status %0d value %0d index %0d last %0d",
                        got.status, got.value_out, got.index_out, got.last);
         end else begin
            want = owed_beats.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display({"beat %0d: expected status %0d value %0d index %0d last %0d,",
                            " got status %0d value %0d index %0d last %0d"},
                           beats_checked, want.status, want.value_out, want.index_out,
                           want.last, got.status, got.value_out, got.index_out, got.last);
            end
         end
      end
   end

   // Watchdog: too long with no beat moving on either channel ends the run.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat accepted for %0d cycles, %0d result beats outstanding",
                     STALL_LIMIT, owed_beats.size());
            $display("bounded_ordered_list_engine test failed");
            $finish;
         end
      end
   end

endmodule
